[design/word_anchored_substring_match_unit_macros.svh]
// Assertion helpers shared by the matcher top level.
`ifndef WORD_ANCHORED_SUBSTRING_MATCH_UNIT_MACROS_SVH
`define WORD_ANCHORED_SUBSTRING_MATCH_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define WASM_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define WASM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/wasm_pkg.sv]
package wasm_pkg;

    localparam int QUERY_MAX_DEF = 32;
    localparam int CFG_DATA_W    = 64;
    localparam int CFG_IDX_W     = 3;
    localparam int LEN_W         = 6;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_QUERY_LO     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_QUERY_MID_LO = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_QUERY_MID_HI = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_QUERY_HI     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LENGTH       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ANCHOR       = 3'd5;

    localparam logic [7:0] CH_UPPER_A    = 8'h41;
    localparam logic [7:0] CH_UPPER_Z    = 8'h5A;
    localparam logic [7:0] CASE_OFFSET   = 8'h20;
    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CH_DOT        = 8'h2E;
    localparam logic [7:0] CH_EQUALS     = 8'h3D;
    localparam logic [7:0] CH_SPACE      = 8'h20;
    localparam logic [7:0] CH_TAB        = 8'h09;
    localparam logic [7:0] CH_CR         = 8'h0D;

    // Per-cycle control broadcast along the row of cells.
    typedef struct packed {
        logic step;   // a text byte is transferred this cycle
        logic last;   // that byte closes the text
    } cell_ctl_t;

    function automatic logic [7:0] fold_byte(input logic [7:0] c);
        fold_byte = (c >= CH_UPPER_A && c <= CH_UPPER_Z) ? c + CASE_OFFSET : c;
    endfunction

    function automatic logic is_break(input logic [7:0] c);
        is_break = (c == CH_UNDERSCORE) || (c == CH_DOT) || (c == CH_EQUALS) ||
                   (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    endfunction

endpackage

[design/wasm_cell.sv]
module wasm_cell (
    input  logic              clk,
    input  logic              rst_n,
    input  wasm_pkg::cell_ctl_t ctl,
    input  logic              q_we,
    input  logic [7:0]        q_data,
    input  logic [7:0]        text_fold,
    input  logic              lane_en,
    input  logic              hit_left,
    output logic              hit_now,
    output logic              hit_q
);
    import wasm_pkg::*;

    logic [7:0] qbyte_reg;
    logic       hit_reg;
    logic       hit_next;

    // The query byte is kept already folded, so only the text needs folding.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qbyte_reg <= '0;
            hit_reg   <= 1'b0;
        end
        else
        begin
            if (q_we)
            begin
                qbyte_reg <= fold_byte(q_data);
            end
            hit_reg <= hit_next;
        end
    end

    assign hit_now = hit_left & lane_en & (qbyte_reg == text_fold);

    always_comb
    begin
        hit_next = hit_reg;
        if (ctl.step)
        begin
            hit_next = ctl.last ? 1'b0 : hit_now;
        end
    end

    assign hit_q = hit_reg;

endmodule

[design/word_anchored_substring_match_unit.sv]
// Word-anchored, case-insensitive substring matcher.
// Text bytes enter on the input channel (in_valid/in_ready) with first_char and
// last_char marking the bounds of a text. For every byte transferred in, exactly
// one result is transferred out on the output channel (out_valid/out_ready):
// matched tells whether the query has occurred so far in the current text, and
// text_end repeats last_char, so that matched on that result is the verdict.
// A result appears in the cycle after its byte is transferred. One byte per
// cycle is sustained while the receiver keeps up: the whole partial-match row
// of cells updates together, and the output register is refilled in the same
// cycle that it is emptied. When the receiver stalls, the result is held and
// in_ready falls until the held result is transferred; no state is lost.
// Reset clears the partial matches and the found flag, sets the query to all
// zero bytes, the length to one and anchoring off. The configuration port
// (cfg_we, cfg_index, cfg_data) must be written while the block is idle; the
// block does not enforce this. A written value applies from the next byte on.
module word_anchored_substring_match_unit #(
    parameter int QUERY_MAX = wasm_pkg::QUERY_MAX_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [7:0]                      text_char,
    input  logic                            first_char,
    input  logic                            last_char,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic                            matched,
    output logic                            text_end,
    input  logic                            cfg_we,
    input  logic [wasm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [wasm_pkg::CFG_DATA_W-1:0] cfg_data
);
    import wasm_pkg::*;

    localparam int IDX_W = (QUERY_MAX > 1) ? $clog2(QUERY_MAX) : 1;

    // Configuration registers outside the cells.
    logic [LEN_W-1:0] len_reg;
    logic             anchor_reg;

    // Text-level state.
    logic found_reg, found_next;
    logic pwb_reg, pwb_next;

    // Output register.
    logic out_valid_reg, out_valid_next;
    logic matched_reg, matched_next;
    logic text_end_reg, text_end_next;

    logic             accept;
    cell_ctl_t        ctl;
    logic [7:0]       text_fold;
    logic [LEN_W-1:0] eff_len;
    logic [IDX_W-1:0] len_idx;
    logic [QUERY_MAX-1:0] lane_en;
    logic [QUERY_MAX-1:0] hit_left;
    logic [QUERY_MAX-1:0] hit_now;
    logic [QUERY_MAX-1:0] hit_q;
    logic             pwb_base;
    logic             start_ok;
    logic             found_now;

    // The output register empties and refills in the same cycle, so the input
    // only waits while a result is held against a stalled receiver.
    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    assign ctl.step  = accept;
    assign ctl.last  = last_char;
    assign text_fold = fold_byte(text_char);

    // A length of zero behaves as one; anything above the row length saturates.
    always_comb
    begin
        if (len_reg == '0)
        begin
            eff_len = LEN_W'(1);
        end
        else if (len_reg > LEN_W'(QUERY_MAX))
        begin
            eff_len = LEN_W'(QUERY_MAX);
        end
        else
        begin
            eff_len = len_reg;
        end
    end
    assign len_idx = IDX_W'(eff_len - LEN_W'(1));

    // A first mark counts as a text start before its byte is looked at. In
    // anchored mode a new partial match may open only at such a start or just
    // after a break byte.
    assign pwb_base = first_char | pwb_reg;
    assign start_ok = !anchor_reg || pwb_base;

    genvar j;
    generate
        for (j = 0; j < QUERY_MAX; j++)
        begin : g_cell
            logic q_we;

            assign q_we       = cfg_we && (cfg_index == CFG_IDX_W'(j / 8));
            assign lane_en[j] = LEN_W'(j) < eff_len;

            // Cell zero is fed the start condition; every other cell takes the
            // stored bit of its left neighbour, which a first mark wipes out.
            if (j == 0)
            begin : g_head
                assign hit_left[j] = start_ok;
            end
            else
            begin : g_body
                assign hit_left[j] = hit_q[j-1] & ~first_char;
            end

            wasm_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctl       (ctl),
                .q_we      (q_we),
                .q_data    (cfg_data[8*(j%8) +: 8]),
                .text_fold (text_fold),
                .lane_en   (lane_en[j]),
                .hit_left  (hit_left[j]),
                .hit_now   (hit_now[j]),
                .hit_q     (hit_q[j])
            );
        end
    endgenerate

    // A full match is the cell at the query length reporting a hit.
    assign found_now = (found_reg & ~first_char) | hit_now[len_idx];

    always_comb
    begin
        found_next     = found_reg;
        pwb_next       = pwb_reg;
        out_valid_next = out_valid_reg;
        matched_next   = matched_reg;
        text_end_next  = text_end_reg;
        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (accept)
        begin
            out_valid_next = 1'b1;
            matched_next   = found_now;
            text_end_next  = last_char;
            // After the last byte of a text the next byte opens a new one.
            found_next     = last_char ? 1'b0 : found_now;
            pwb_next       = last_char ? 1'b1 : is_break(text_char);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg       <= LEN_W'(1);
            anchor_reg    <= 1'b0;
            found_reg     <= 1'b0;
            pwb_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_LENGTH: len_reg    <= cfg_data[LEN_W-1:0];
                    CFG_ANCHOR: anchor_reg <= cfg_data[0];
                    default:    ;
                endcase
            end
            found_reg     <= found_next;
            pwb_reg       <= pwb_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        matched_reg  <= matched_next;
        text_end_reg <= text_end_next;
    end

    assign out_valid = out_valid_reg;
    assign matched   = matched_reg;
    assign text_end  = text_end_reg;

`include "word_anchored_substring_match_unit_macros.svh"

    // Every transferred byte leaves a result in the output register.
    `WASM_ASSERT_NEXT(a_result_follows, accept, out_valid, "byte transferred without result")
    // A text's closing byte leaves the row cleared and the next byte anchored.
    `WASM_ASSERT_NEXT(a_text_flush, accept && last_char, (hit_q == '0) && !found_reg && pwb_reg, "state not cleared after last byte")
    // Once found, a text stays found until it ends or restarts.
    `WASM_ASSERT_NEXT(a_found_sticky, accept && found_reg && !first_char, matched, "found flag lost within a text")
    // A held result blocks new input.
    `WASM_ASSERT_SAME(a_stall_blocks, out_valid && !out_ready, !in_ready, "input taken over a held result")

endmodule

[sim/word_anchored_substring_match_unit_tb.sv]
// Testbench for the word-anchored, case-insensitive substring matcher.
//
// The block takes one text byte per input transfer and returns exactly one
// verdict per byte on the output channel. A small scoreboard class keeps its
// own copy of the query registers and of the shift-and state. It works out the
// verdict of every byte at the moment that byte is transferred in, and it checks
// each result transferred out against the oldest verdict still waiting.
//
// The stimulus opens with a short directed part, then runs a series of phases.
// Each phase programs every register while the block is idle and then streams
// texts built mostly around the query, so that full and partial matches,
// anchoring at separators and texts with missing marks are all reached.
module word_anchored_substring_match_unit_tb;

    localparam int QUERY_MAX        = wasm_pkg::QUERY_MAX_DEF;
    localparam int PHASES           = 12;
    localparam int BYTES_PER_PHASE  = 120;
    localparam int LONG_HOLD_CYCLES = 200;
    localparam int REG_COUNT        = 6;

    // One expected result: the running verdict and the copy of the last mark.
    typedef struct packed {
        logic matched;
        logic text_end;
    } verdict_t;

    // The scoreboard holds the predicted behaviour of the block and the queue of
    // verdicts for bytes that have been transferred in but not yet answered.
    class match_scoreboard;
        logic [63:0] query_words [4];
        logic [5:0]  query_len;
        logic        anchored;
        logic [31:0] prefix_vec;
        logic        after_break;
        logic        seen_match;
        verdict_t    verdicts [$];
        int          errors;
        int          texts_closed;
        int          texts_matched;

        function new();
            foreach (query_words[i]) query_words[i] = '0;
            query_len     = 6'd1;
            anchored      = 1'b0;
            prefix_vec    = '0;
            after_break   = 1'b0;
            seen_match    = 1'b0;
            errors        = 0;
            texts_closed  = 0;
            texts_matched = 0;
        endfunction

        function logic [7:0] lower_ascii(logic [7:0] c);
            if (c >= wasm_pkg::CH_UPPER_A && c <= wasm_pkg::CH_UPPER_Z)
                return c + wasm_pkg::CASE_OFFSET;
            return c;
        endfunction

        function logic is_separator(logic [7:0] c);
            return c == wasm_pkg::CH_UNDERSCORE || c == wasm_pkg::CH_DOT ||
                   c == wasm_pkg::CH_EQUALS || c == wasm_pkg::CH_SPACE ||
                   (c >= wasm_pkg::CH_TAB && c <= wasm_pkg::CH_CR);
        endfunction

        function void write_reg(logic [wasm_pkg::CFG_IDX_W-1:0] idx, logic [63:0] data);
            case (idx)
                wasm_pkg::CFG_QUERY_LO:     query_words[0] = data;
                wasm_pkg::CFG_QUERY_MID_LO: query_words[1] = data;
                wasm_pkg::CFG_QUERY_MID_HI: query_words[2] = data;
                wasm_pkg::CFG_QUERY_HI:     query_words[3] = data;
                wasm_pkg::CFG_LENGTH:       query_len = data[5:0];
                wasm_pkg::CFG_ANCHOR:       anchored = data[0];
                default: ;
            endcase
        endfunction

        // Query length in use: zero counts as one, and it saturates at the row size.
        function int span();
            if (query_len == 6'd0) return 1;
            if (query_len > QUERY_MAX) return QUERY_MAX;
            return int'(query_len);
        endfunction

        function void note_byte(logic [7:0] c, logic first, logic last);
            logic [31:0] same;
            logic [7:0]  qb;
            logic        start;
            verdict_t    v;
            int          n;
            n = span();
            same = '0;
            // A first mark opens a new text before the byte itself is looked at.
            if (first)
            begin
                prefix_vec  = '0;
                seen_match  = 1'b0;
                after_break = 1'b1;
            end
            for (int k = 0; k < n; k++)
            begin
                qb = query_words[k / 8][(k % 8) * 8 +: 8];
                if (lower_ascii(qb) == lower_ascii(c)) same[k] = 1'b1;
            end
            start = !anchored || after_break;
            prefix_vec = ((prefix_vec << 1) | {31'd0, start}) & same;
            if (prefix_vec[n-1]) seen_match = 1'b1;
            after_break = is_separator(c);
            v.matched  = seen_match;
            v.text_end = last;
            verdicts.insert(verdicts.size(), v);
            // After a last mark the next byte starts a fresh text in any case.
            if (last)
            begin
                prefix_vec  = '0;
                seen_match  = 1'b0;
                after_break = 1'b1;
            end
        endfunction

        function void check_result(logic got_matched, logic got_end);
            verdict_t want;
            if (verdicts.size() == 0)
            begin
                $error("result transferred with no byte outstanding: matched=%0b text_end=%0b",
                       got_matched, got_end);
                errors++;
                return;
            end
            want = verdicts.pop_front();
            if (got_matched !== want.matched)
            begin
                $error("matched: expected %0b, actual %0b", want.matched, got_matched);
                errors++;
            end
            if (got_end !== want.text_end)
            begin
                $error("text_end: expected %0b, actual %0b", want.text_end, got_end);
                errors++;
            end
            if (got_end === 1'b1)
            begin
                texts_closed++;
                if (got_matched === 1'b1) texts_matched++;
            end
        endfunction
    endclass

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            in_valid = 1'b0;
    logic                            in_ready;
    logic [7:0]                      text_char = 8'd0;
    logic                            first_char = 1'b0;
    logic                            last_char = 1'b0;
    logic                            out_valid;
    logic                            out_ready = 1'b0;
    logic                            matched;
    logic                            text_end;
    logic                            cfg_we = 1'b0;
    logic [wasm_pkg::CFG_IDX_W-1:0]  cfg_index = wasm_pkg::CFG_QUERY_LO;
    logic [wasm_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    match_scoreboard sb = new();

    // Register image to be programmed, in the order of the register indexes,
    // and the query bytes that the text generator draws on.
    logic [63:0] reg_image [REG_COUNT];
    logic [7:0]  qbytes [QUERY_MAX];
    int          active_len = 1;
    int          sent_bytes = 0;
    int          settings_used = 0;

    // quiet turns all idling off for the closing part of the run; steady does so
    // for the sender only, for the length of one text; long_hold asks the
    // receiver for one long stall.
    bit quiet = 1'b0;
    bit steady = 1'b0;
    bit long_hold = 1'b0;

    word_anchored_substring_match_unit dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .text_char  (text_char),
        .first_char (first_char),
        .last_char  (last_char),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .matched    (matched),
        .text_end   (text_end),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Watchdog: a correct run finishes far inside this time.
    initial
    begin
        #5_000_000;
        $display("FAIL");
        $finish;
    end

    // Both channels are sampled at the rising edge, where every input driven by
    // this bench still holds its old value. The result is checked before the new
    // byte is noted, so that a stray result can never be matched against a byte
    // transferred in at the same edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready) sb.check_result(matched, text_end);
            if (in_valid && in_ready) sb.note_byte(text_char, first_char, last_char);
        end
    end

    // Receiver: stalls drawn at random between stretches of readiness.
    // On request it stalls for one long, counted stretch so that the block fills
    // and holds its input off while the sender keeps offering bytes.
    initial
    begin
        forever
        begin
            if (long_hold)
            begin
                out_ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge clk);
                long_hold = 1'b0;
            end
            else if (!quiet && $urandom_range(0, 3) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge clk);
            end
            else
            begin
                out_ready <= 1'b1;
                repeat ($urandom_range(1, 24)) @(posedge clk);
            end
        end
    end

    function automatic logic [7:0] flip_case(logic [7:0] c);
        logic letter;
        letter = (c >= wasm_pkg::CH_UPPER_A && c <= wasm_pkg::CH_UPPER_Z) ||
                 (c >= wasm_pkg::CH_UPPER_A + wasm_pkg::CASE_OFFSET &&
                  c <= wasm_pkg::CH_UPPER_Z + wasm_pkg::CASE_OFFSET);
        return (letter && $urandom_range(0, 1) == 1) ? c ^ wasm_pkg::CASE_OFFSET : c;
    endfunction

    function automatic logic [7:0] separator_byte();
        int pick;
        pick = $urandom_range(0, 8);
        case (pick)
            0:       return wasm_pkg::CH_UNDERSCORE;
            1:       return wasm_pkg::CH_DOT;
            2:       return wasm_pkg::CH_EQUALS;
            3:       return wasm_pkg::CH_SPACE;
            default: return wasm_pkg::CH_TAB + 8'(pick - 4);
        endcase
    endfunction

    // Filler leans on the query's own bytes so that partial matches build up,
    // with separators, arbitrary bytes and bytes of the upper half mixed in.
    function automatic logic [7:0] filler_byte();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return flip_case(qbytes[$urandom_range(0, active_len - 1)]);
            5, 6:          return separator_byte();
            7:             return 8'($urandom_range(0, 255));
            8:             return 8'($urandom_range(128, 255));
            default:       return flip_case(qbytes[0]);
        endcase
    endfunction

    function automatic logic [wasm_pkg::CFG_IDX_W-1:0] reg_code(int i);
        case (i)
            0:       return wasm_pkg::CFG_QUERY_LO;
            1:       return wasm_pkg::CFG_QUERY_MID_LO;
            2:       return wasm_pkg::CFG_QUERY_MID_HI;
            3:       return wasm_pkg::CFG_QUERY_HI;
            4:       return wasm_pkg::CFG_LENGTH;
            default: return wasm_pkg::CFG_ANCHOR;
        endcase
    endfunction

    // Offers one byte and returns at the edge where it is transferred. Valid is
    // left high afterwards, so the next byte follows back to back unless an idle
    // burst lowers it first.
    task automatic send_byte(input logic [7:0] c, input logic first, input logic last);
        if (!quiet && !steady && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        in_valid   <= 1'b1;
        text_char  <= c;
        first_char <= first;
        last_char  <= last;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sent_bytes++;
    endtask

    // Stops offering and waits until every verdict has come back, then lets the
    // single stage of the block settle.
    task automatic wait_until_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.verdicts.size() != 0) @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    // Writes the whole register image while the block is idle, one register per
    // cycle with the write enable held high across the burst.
    task automatic commit_regs();
        wait_until_drained();
        for (int i = 0; i < REG_COUNT; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= reg_code(i);
            cfg_data  <= reg_image[i];
            sb.write_reg(reg_code(i), reg_image[i]);
            @(posedge clk);
        end
        cfg_we <= 1'b0;
        for (int k = 0; k < QUERY_MAX; k++) qbytes[k] = reg_image[k / 8][(k % 8) * 8 +: 8];
        active_len = sb.span();
        settings_used++;
    endtask

    // Picks a register setting for one phase. The early phases take the length
    // extremes, including zero and values beyond the row size; the alphabet of
    // the query rotates between a few letters, any byte, and a mixture.
    task automatic configure_phase(input int p);
        logic [5:0] len6;
        logic [7:0] b;
        case (p)
            0:       len6 = 6'd1;
            1:       len6 = 6'd32;
            2:       len6 = 6'd0;
            3:       len6 = 6'd63;
            4:       len6 = 6'd33;
            default: len6 = 6'($urandom_range(2, 12));
        endcase
        for (int k = 0; k < QUERY_MAX; k++)
        begin
            if (p == 1) b = 8'hFF;
            else if (p % 3 == 0) b = flip_case(8'h61 + 8'($urandom_range(0, 2)));
            else if (p % 3 == 1) b = 8'($urandom_range(0, 255));
            else
            begin
                case ($urandom_range(0, 3))
                    0:       b = flip_case(8'h61 + 8'($urandom_range(0, 3)));
                    1:       b = separator_byte();
                    2:       b = 8'($urandom_range(128, 255));
                    default: b = 8'($urandom_range(8'h30, 8'h39));
                endcase
            end
            reg_image[k / 8][(k % 8) * 8 +: 8] = b;
        end
        // Upper bits of the narrow registers carry noise that the block drops.
        reg_image[4] = {$urandom, $urandom};
        reg_image[4][5:0] = len6;
        reg_image[5] = {$urandom, $urandom};
        reg_image[5][0] = 1'(p % 2);
        commit_regs();
    endtask

    // One text: either the query planted among filler (now and then cut short,
    // sometimes right after a separator) or filler alone. Marks are now and then
    // left out, and a stray first mark may split the text.
    task automatic send_text();
        logic [7:0] body [$];
        int         pre;
        int         post;
        int         cut;
        int         n;
        int         stray;
        bit         mark_first;
        bit         mark_last;
        if ($urandom_range(0, 1) == 1)
        begin
            pre  = $urandom_range(0, 4);
            post = $urandom_range(0, 4);
            cut  = active_len;
            if (active_len > 1 && $urandom_range(0, 5) == 0)
                cut = $urandom_range(1, active_len - 1);
            repeat (pre) body.insert(body.size(), filler_byte());
            if ($urandom_range(0, 1) == 1) body.insert(body.size(), separator_byte());
            for (int k = 0; k < cut; k++) body.insert(body.size(), flip_case(qbytes[k]));
            repeat (post) body.insert(body.size(), filler_byte());
        end
        else
        begin
            n = $urandom_range(1, active_len + 6);
            repeat (n) body.insert(body.size(), filler_byte());
        end
        mark_first = $urandom_range(0, 7) != 0;
        mark_last  = $urandom_range(0, 7) != 0;
        stray      = ($urandom_range(0, 9) == 0) ? $urandom_range(0, body.size() - 1) : -1;
        steady     = $urandom_range(0, 2) == 0;
        foreach (body[i])
            send_byte(body[i], (i == 0 && mark_first) || i == stray,
                      i == body.size() - 1 && mark_last);
    endtask

    initial
    begin
        int  phase_start;
        bit  paused;
        paused = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Straight after reset the query is one zero byte, and these bytes carry
        // no first mark, so they count as the middle of a text.
        send_byte(8'h00, 1'b0, 1'b0);
        send_byte(8'hFF, 1'b0, 1'b1);

        // Anchored two-byte query with mixed case; unused words set to all ones.
        reg_image[0] = 64'h0000_0000_0000_4261;
        reg_image[1] = '1;
        reg_image[2] = '1;
        reg_image[3] = '1;
        reg_image[4] = 64'd2;
        reg_image[5] = 64'd1;
        commit_regs();
        send_byte("A", 1'b1, 1'b0);
        send_byte("b", 1'b0, 1'b1);
        // Not at a word start, so no match when anchored.
        send_byte("x", 1'b1, 1'b0);
        send_byte("a", 1'b0, 1'b0);
        send_byte("b", 1'b0, 1'b1);
        // A separator opens a word in the middle of the text.
        send_byte("x", 1'b1, 1'b0);
        send_byte(wasm_pkg::CH_UNDERSCORE, 1'b0, 1'b0);
        send_byte("A", 1'b0, 1'b0);
        send_byte("B", 1'b0, 1'b1);
        // A match may not run across the end of a text, with or without a first mark.
        send_byte("a", 1'b1, 1'b1);
        send_byte("b", 1'b0, 1'b1);
        // A first mark in mid-text throws away the partial match.
        send_byte("a", 1'b1, 1'b0);
        send_byte("b", 1'b1, 1'b1);

        // Length zero acts as one; bytes of the upper half are never folded.
        reg_image[0] = 64'h0000_0000_0000_00C1;
        reg_image[1] = '0;
        reg_image[2] = '0;
        reg_image[3] = '0;
        reg_image[4] = 64'hFFFF_FFFF_FFFF_FFC0;
        reg_image[5] = 64'hFFFF_FFFF_FFFF_FFFE;
        commit_regs();
        send_byte(8'hE1, 1'b1, 1'b0);
        send_byte(8'hC1, 1'b0, 1'b1);

        for (int p = 0; p < PHASES; p++)
        begin
            configure_phase(p);
            if (p == PHASES - 1) quiet = 1'b1;
            if (p == 3) long_hold = 1'b1;
            phase_start = sent_bytes;
            while (sent_bytes - phase_start < BYTES_PER_PHASE)
            begin
                send_text();
                // Once in the run the sender pauses mid-phase until all is answered.
                if (p == 6 && !paused && sent_bytes - phase_start >= BYTES_PER_PHASE / 2)
                begin
                    wait_until_drained();
                    paused = 1'b1;
                end
            end
        end

        wait_until_drained();
        repeat (5) @(posedge clk);

        $display("Streamed %0d bytes under %0d register settings; %0d texts closed, %0d matched.",
                 sent_bytes, settings_used, sb.texts_closed, sb.texts_matched);
        if (sb.errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
